/* hw/rtl/vpw_pkg.sv */
// vpw_pkg: shared widths, configuration register codes, payload structs and
// saturation helpers for the vertex projection pipeline.
// No dependencies.
package vpw_pkg;

  localparam int COEF_W    = 16;
  localparam int OBJ_W     = 16;
  localparam int VIEW_W    = 15;
  localparam int WIN_W     = 24;
  localparam int DEPTH_W   = 16;
  localparam int ROW_W     = 64;
  localparam int NUM_ROWS  = 4;
  localparam int PIX_FRAC  = 8;
  // quotient bits kept by the divider; larger magnitudes saturate anyway
  localparam int QUO_W     = 25;
  localparam int IN_DATA_W  = 112;
  localparam int OUT_DATA_W = 64;

  localparam logic [VIEW_W-1:0] VIEW_MAX  = 15'd16384;
  localparam logic [ROW_W-1:0]  IDENT_ONE = 64'h1000;

  typedef enum logic [2:0] {
    CFG_MODEL_ROW0 = 3'd0,
    CFG_MODEL_ROW1 = 3'd1,
    CFG_MODEL_ROW2 = 3'd2,
    CFG_MODEL_ROW3 = 3'd3,
    CFG_PROJ_ROW0  = 3'd4,
    CFG_PROJ_ROW1  = 3'd5,
    CFG_PROJ_ROW2  = 3'd6,
    CFG_PROJ_ROW3  = 3'd7
  } cfg_idx_e;

  typedef struct packed {
    logic signed [VIEW_W-1:0] left;
    logic signed [VIEW_W-1:0] bottom;
    logic [VIEW_W-1:0]        width;
    logic [VIEW_W-1:0]        height;
  } view_t;

  typedef struct packed {
    logic signed [VIEW_W-1:0] left;
    logic signed [VIEW_W-1:0] bottom;
    logic                     visible;
    logic [2:0]               neg;
  } div_side_t;

  function automatic logic [WIN_W-1:0] sat_win(logic signed [QUO_W+1:0] v);
    logic signed [QUO_W+1:0] hi;
    logic signed [QUO_W+1:0] lo;
    hi = (QUO_W+2)'((1 << (WIN_W-1)) - 1);
    lo = ~hi;
    if (v > hi) return hi[WIN_W-1:0];
    if (v < lo) return lo[WIN_W-1:0];
    return v[WIN_W-1:0];
  endfunction

  function automatic logic [DEPTH_W-1:0] sat_depth(logic signed [QUO_W:0] v);
    logic signed [QUO_W:0] hi;
    logic signed [QUO_W:0] lo;
    hi = (QUO_W+1)'((1 << (DEPTH_W-1)) - 1);
    lo = ~hi;
    if (v > hi) return hi[DEPTH_W-1:0];
    if (v < lo) return lo[DEPTH_W-1:0];
    return v[DEPTH_W-1:0];
  endfunction

endpackage

/* hw/rtl/vpw_matvec.sv */
// vpw_matvec: two-stage 4x4 matrix times vector with rescale and saturation.
// Stage 0 registers the sixteen products, stage 1 the saturated row sums.
// Depends on vpw_pkg.
module vpw_matvec import vpw_pkg::*; #(
  parameter int IN_W   = 16,
  parameter int OUT_W  = 32,
  parameter int LSHIFT = 0,
  parameter int RSHIFT = 0,
  parameter int SIDE_W = 60
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [NUM_ROWS-1:0][IN_W-1:0]    vec_i,
  input  logic [SIDE_W-1:0]                side_i,
  input  logic [NUM_ROWS-1:0][ROW_W-1:0]   rows_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [NUM_ROWS-1:0][OUT_W-1:0]   vec_o,
  output logic [SIDE_W-1:0]                side_o
);

  localparam int PROD_W = COEF_W + IN_W;
  localparam int SUM_W  = PROD_W + 2;
  localparam int SCL_W  = SUM_W + LSHIFT;
  localparam int EXT_W  = ((SCL_W > OUT_W) ? SCL_W : OUT_W) + 1;
  localparam logic signed [EXT_W-1:0] SAT_HI = (EXT_W'(1) << (OUT_W-1)) - EXT_W'(1);
  localparam logic signed [EXT_W-1:0] SAT_LO = ~SAT_HI;

  logic v0_q, v1_q, en0, en1;
  logic signed [PROD_W-1:0] prod_d [NUM_ROWS][NUM_ROWS];
  logic signed [PROD_W-1:0] prod_q [NUM_ROWS][NUM_ROWS];
  logic [SIDE_W-1:0] side0_q, side1_q;
  logic [NUM_ROWS-1:0][OUT_W-1:0] res_d, res_q;

  assign en1        = ~v1_q | out_ready_i;
  assign en0        = ~v0_q | en1;
  assign in_ready_o = en0;

  always_comb begin
    for (int i = 0; i < NUM_ROWS; i++) begin
      for (int k = 0; k < NUM_ROWS; k++) begin
        prod_d[i][k] = $signed(rows_i[i][COEF_W*k +: COEF_W]) * $signed(vec_i[k]);
      end
    end
  end

  always_comb begin
    logic signed [SUM_W-1:0] sum;
    logic signed [SCL_W-1:0] scl;
    logic signed [EXT_W-1:0] ext;
    for (int i = 0; i < NUM_ROWS; i++) begin
      sum = SUM_W'(prod_q[i][0]) + SUM_W'(prod_q[i][1])
          + SUM_W'(prod_q[i][2]) + SUM_W'(prod_q[i][3]);
      scl = SCL_W'(sum) <<< LSHIFT;
      scl = scl >>> RSHIFT;
      ext = EXT_W'(scl);
      if (ext > SAT_HI) begin
        ext = SAT_HI;
      end else if (ext < SAT_LO) begin
        ext = SAT_LO;
      end
      res_d[i] = ext[OUT_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
    end else begin
      if (en0) v0_q <= in_valid_i;
      if (en1) v1_q <= v0_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en0) begin
      prod_q  <= prod_d;
      side0_q <= side_i;
    end
    if (en1) begin
      res_q   <= res_d;
      side1_q <= side0_q;
    end
  end

  assign out_valid_o = v1_q;
  assign vec_o       = res_q;
  assign side_o      = side1_q;

endmodule

/* hw/rtl/vpw_setup.sv */
// vpw_setup: one stage that checks clip w, forms the three division
// numerators (sign folded to magnitudes) and the divisor 2w.
// Depends on vpw_pkg.
module vpw_setup import vpw_pkg::*; #(
  parameter int COEF_FRAC_BITS     = 12,
  parameter int INTERNAL_FRAC_BITS = 24
) (
  input  logic                                         clk_i,
  input  logic                                         rst_ni,
  input  logic                                         in_valid_i,
  output logic                                         in_ready_o,
  input  logic [NUM_ROWS-1:0][INTERNAL_FRAC_BITS+7:0]  clip_i,
  input  view_t                                        view_i,
  output logic                                         out_valid_o,
  input  logic                                         out_ready_i,
  output logic [2:0][INTERNAL_FRAC_BITS+31:0]          mag_o,
  output logic [INTERNAL_FRAC_BITS+8:0]                div_o,
  output div_side_t                                    side_o
);

  localparam int CLIP_W = INTERNAL_FRAC_BITS + 8;
  localparam int NUM_W  = CLIP_W + 25;
  localparam int MAG_W  = NUM_W - 1;
  localparam longint W_MIN_L = ((64'sd1 <<< INTERNAL_FRAC_BITS) + 64'sd5000) / 64'sd10000;
  localparam logic signed [CLIP_W-1:0] W_MIN = CLIP_W'(W_MIN_L);

  logic v_q, en;
  logic [2:0][MAG_W-1:0] mag_d, mag_q;
  logic [CLIP_W:0] div_d, div_q;
  div_side_t side_d, side_q;

  assign en         = ~v_q | out_ready_i;
  assign in_ready_o = en;

  always_comb begin
    logic signed [CLIP_W-1:0] w;
    logic signed [CLIP_W:0]   sx [3];
    logic signed [NUM_W-1:0]  num [3];
    logic [VIEW_W-1:0]        wid, hgt;
    w   = $signed(clip_i[3]);
    wid = (view_i.width  > VIEW_MAX) ? VIEW_MAX : view_i.width;
    hgt = (view_i.height > VIEW_MAX) ? VIEW_MAX : view_i.height;
    for (int l = 0; l < 3; l++) begin
      sx[l] = (CLIP_W+1)'(w) + (CLIP_W+1)'($signed(clip_i[l]));
    end
    num[0] = sx[0] * $signed({1'b0, wid});
    num[0] = num[0] <<< PIX_FRAC;
    num[1] = sx[1] * $signed({1'b0, hgt});
    num[1] = num[1] <<< PIX_FRAC;
    num[2] = NUM_W'(sx[2]) <<< COEF_FRAC_BITS;
    for (int l = 0; l < 3; l++) begin
      side_d.neg[l] = num[l][NUM_W-1];
      mag_d[l]      = num[l][NUM_W-1] ? ~num[l][MAG_W-1:0] : num[l][MAG_W-1:0];
    end
    div_d          = {w, 1'b0};
    side_d.visible = (w >= W_MIN);
    side_d.left    = view_i.left;
    side_d.bottom  = view_i.bottom;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (en) begin
      v_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      mag_q  <= mag_d;
      div_q  <= div_d;
      side_q <= side_d;
    end
  end

  assign out_valid_o = v_q;
  assign mag_o       = mag_q;
  assign div_o       = div_q;
  assign side_o      = side_q;

endmodule

/* hw/rtl/vpw_divider.sv */
// vpw_divider: pipelined restoring divider, three lanes sharing one divisor,
// an overflow check stage then one quotient bit per stage.
// Depends on vpw_pkg.
module vpw_divider import vpw_pkg::*; #(
  parameter int CLIP_W = 32,
  parameter int MAG_W  = 56
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [2:0][MAG_W-1:0]       mag_i,
  input  logic [CLIP_W:0]             div_i,
  input  div_side_t                   side_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [2:0][QUO_W-1:0]       quo_o,
  output div_side_t                   side_o
);

  localparam int RW  = CLIP_W + 1 + QUO_W;
  localparam int NST = QUO_W + 1;

  logic [NST-1:0] v_q;
  logic [NST-1:0] en;
  logic [RW-1:0]     rem_q [NST][3];
  logic [QUO_W-1:0]  quo_q [NST][3];
  logic [2:0]        ovf_q [NST];
  logic [CLIP_W:0]   div_q [NST];
  div_side_t         side_q [NST];

  assign en[NST-1]  = ~v_q[NST-1] | out_ready_i;
  assign in_ready_o = en[0];

  for (genvar s = 0; s < NST - 1; s++) begin : g_en
    assign en[s] = ~v_q[s] | en[s+1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      for (int s = 0; s < NST; s++) begin
        if (en[s]) v_q[s] <= (s == 0) ? in_valid_i : v_q[(s == 0) ? 0 : s-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      for (int l = 0; l < 3; l++) begin
        rem_q[0][l] <= RW'(mag_i[l]);
        quo_q[0][l] <= '0;
        ovf_q[0][l] <= RW'(mag_i[l]) >= (RW'(div_i) << QUO_W);
      end
      div_q[0]  <= div_i;
      side_q[0] <= side_i;
    end
  end

  for (genvar s = 1; s < NST; s++) begin : g_stage
    logic [RW:0]   diff [3];
    logic [RW-1:0] shd;
    logic [2:0]    take;

    always_comb begin
      shd = RW'(div_q[s-1]) << (QUO_W - s);
      for (int l = 0; l < 3; l++) begin
        diff[l] = {1'b0, rem_q[s-1][l]} - {1'b0, shd};
        take[l] = ~diff[l][RW];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en[s]) begin
        for (int l = 0; l < 3; l++) begin
          rem_q[s][l] <= take[l] ? diff[l][RW-1:0] : rem_q[s-1][l];
          quo_q[s][l] <= quo_q[s-1][l] | (QUO_W'(take[l]) << (QUO_W - s));
        end
        ovf_q[s]  <= ovf_q[s-1];
        div_q[s]  <= div_q[s-1];
        side_q[s] <= side_q[s-1];
      end
    end
  end

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      quo_o[l] = ovf_q[NST-1][l] ? '1 : quo_q[NST-1][l];
    end
  end

  assign out_valid_o = v_q[NST-1];
  assign side_o      = side_q[NST-1];

`ifndef SYNTHESIS
  a_rem_below_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[NST-1] && side_q[NST-1].visible |->
      (ovf_q[NST-1][0] || rem_q[NST-1][0] < RW'(div_q[NST-1])) &&
      (ovf_q[NST-1][1] || rem_q[NST-1][1] < RW'(div_q[NST-1])) &&
      (ovf_q[NST-1][2] || rem_q[NST-1][2] < RW'(div_q[NST-1])))
    else $error("divider remainder not below divisor");

  a_div_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && side_i.visible |-> div_i != '0)
    else $error("visible item with zero divisor");
`endif

endmodule

/* hw/rtl/vertex_project_to_window_core.sv */
// vertex_project_to_window_core: model and projection transform, clip check,
// pipelined perspective divide and viewport mapping. Uses vpw_pkg, vpw_matvec,
// vpw_setup and vpw_divider.
//
//  channel   dir  handshake                   payload
//  s_axis    in   s_axis_tvalid/tready        obj_x..view_height in tdata
//  m_axis    out  m_axis_tvalid/tready        win_x, win_y, win_depth; visible in tuser
//  cfg       in   cfg_valid_i/cfg_ready_o     cfg_index_i, cfg_data_i
//
// One item per cycle while the output does not stall; stages: model and projection matvec, setup, divider, output.
// The divider pipeline (one quotient bit per stage) sets the depth.
// rst_ni clears all valid bits and loads identity matrices.
// Each stage moves when the next one is empty or moving, so bubbles close up
// under an output stall and nothing is dropped.
module vertex_project_to_window_core import vpw_pkg::*; #(
  parameter int COEF_FRAC_BITS     = 12,
  parameter int INTERNAL_FRAC_BITS = 24
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // obj_x, obj_y, obj_z, view_left, view_bottom, view_width, view_height, pad
  input  logic [IN_DATA_W-1:0]   s_axis_tdata,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // win_x, win_y, win_depth
  output logic [OUT_DATA_W-1:0]  m_axis_tdata,
  // visible
  output logic [0:0]             m_axis_tuser,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [2:0]             cfg_index_i,
  input  logic [ROW_W-1:0]       cfg_data_i
);

  localparam int CLIP_W = INTERNAL_FRAC_BITS + 8;
  localparam int MAG_W  = CLIP_W + 24;
  localparam int OBJ_IN_W = (COEF_FRAC_BITS + 2 > OBJ_W) ? COEF_FRAC_BITS + 2 : OBJ_W;
  localparam int M_LSH = (INTERNAL_FRAC_BITS > 2*COEF_FRAC_BITS) ?
                         INTERNAL_FRAC_BITS - 2*COEF_FRAC_BITS : 0;
  localparam int M_RSH = (2*COEF_FRAC_BITS > INTERNAL_FRAC_BITS) ?
                         2*COEF_FRAC_BITS - INTERNAL_FRAC_BITS : 0;
  localparam int VIEW_BITS = $bits(view_t);

  logic [NUM_ROWS-1:0][ROW_W-1:0] model_rows_q, proj_rows_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_ROWS; i++) begin
        model_rows_q[i] <= IDENT_ONE << (COEF_W*i);
        proj_rows_q[i]  <= IDENT_ONE << (COEF_W*i);
      end
    end else if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_MODEL_ROW0: model_rows_q[0] <= cfg_data_i;
        CFG_MODEL_ROW1: model_rows_q[1] <= cfg_data_i;
        CFG_MODEL_ROW2: model_rows_q[2] <= cfg_data_i;
        CFG_MODEL_ROW3: model_rows_q[3] <= cfg_data_i;
        CFG_PROJ_ROW0:  proj_rows_q[0]  <= cfg_data_i;
        CFG_PROJ_ROW1:  proj_rows_q[1]  <= cfg_data_i;
        CFG_PROJ_ROW2:  proj_rows_q[2]  <= cfg_data_i;
        CFG_PROJ_ROW3:  proj_rows_q[3]  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic [NUM_ROWS-1:0][OBJ_IN_W-1:0] obj_vec;
  view_t view_in;

  always_comb begin
    obj_vec[0]     = OBJ_IN_W'($signed(s_axis_tdata[15:0]));
    obj_vec[1]     = OBJ_IN_W'($signed(s_axis_tdata[31:16]));
    obj_vec[2]     = OBJ_IN_W'($signed(s_axis_tdata[47:32]));
    obj_vec[3]     = OBJ_IN_W'(1) << COEF_FRAC_BITS;
    view_in.left   = s_axis_tdata[62:48];
    view_in.bottom = s_axis_tdata[77:63];
    view_in.width  = s_axis_tdata[92:78];
    view_in.height = s_axis_tdata[107:93];
  end

  logic eye_valid, eye_ready, clip_valid, clip_ready, st_valid, st_ready;
  logic dv_valid, dv_ready;
  logic [NUM_ROWS-1:0][CLIP_W-1:0] eye_vec, clip_vec;
  logic [VIEW_BITS-1:0] eye_side, clip_side;
  logic [2:0][MAG_W-1:0] st_mag;
  logic [CLIP_W:0] st_div;
  div_side_t st_side, dv_side;
  logic [2:0][QUO_W-1:0] dv_quo;

  vpw_matvec #(
    .IN_W(OBJ_IN_W), .OUT_W(CLIP_W), .LSHIFT(M_LSH), .RSHIFT(M_RSH), .SIDE_W(VIEW_BITS)
  ) u_model (
    .clk_i, .rst_ni,
    .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready),
    .vec_i(obj_vec), .side_i(view_in), .rows_i(model_rows_q),
    .out_valid_o(eye_valid), .out_ready_i(eye_ready),
    .vec_o(eye_vec), .side_o(eye_side)
  );

  vpw_matvec #(
    .IN_W(CLIP_W), .OUT_W(CLIP_W), .LSHIFT(0), .RSHIFT(COEF_FRAC_BITS), .SIDE_W(VIEW_BITS)
  ) u_proj (
    .clk_i, .rst_ni,
    .in_valid_i(eye_valid), .in_ready_o(eye_ready),
    .vec_i(eye_vec), .side_i(eye_side), .rows_i(proj_rows_q),
    .out_valid_o(clip_valid), .out_ready_i(clip_ready),
    .vec_o(clip_vec), .side_o(clip_side)
  );

  vpw_setup #(
    .COEF_FRAC_BITS(COEF_FRAC_BITS), .INTERNAL_FRAC_BITS(INTERNAL_FRAC_BITS)
  ) u_setup (
    .clk_i, .rst_ni,
    .in_valid_i(clip_valid), .in_ready_o(clip_ready),
    .clip_i(clip_vec), .view_i(view_t'(clip_side)),
    .out_valid_o(st_valid), .out_ready_i(st_ready),
    .mag_o(st_mag), .div_o(st_div), .side_o(st_side)
  );

  vpw_divider #(
    .CLIP_W(CLIP_W), .MAG_W(MAG_W)
  ) u_div (
    .clk_i, .rst_ni,
    .in_valid_i(st_valid), .in_ready_o(st_ready),
    .mag_i(st_mag), .div_i(st_div), .side_i(st_side),
    .out_valid_o(dv_valid), .out_ready_i(dv_ready),
    .quo_o(dv_quo), .side_o(dv_side)
  );

  // output stage: unfold signs, add viewport origin, saturate, zero invisible items
  logic out_valid_q, fin_en;
  logic [OUT_DATA_W-1:0] out_data_q, out_data_d;
  logic out_vis_q;

  assign fin_en   = ~out_valid_q | m_axis_tready;
  assign dv_ready = fin_en;

  always_comb begin
    logic signed [QUO_W:0]   qs [3];
    logic signed [QUO_W+1:0] wx, wy;
    for (int l = 0; l < 3; l++) begin
      qs[l] = dv_side.neg[l] ? ~{1'b0, dv_quo[l]} : {1'b0, dv_quo[l]};
    end
    wx = (QUO_W+2)'(qs[0]) + ((QUO_W+2)'(dv_side.left) <<< PIX_FRAC);
    wy = (QUO_W+2)'(qs[1]) + ((QUO_W+2)'(dv_side.bottom) <<< PIX_FRAC);
    out_data_d = {sat_depth(qs[2]), sat_win(wy), sat_win(wx)};
    if (!dv_side.visible) out_data_d = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fin_en) begin
      out_valid_q <= dv_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fin_en) begin
      out_data_q <= out_data_d;
      out_vis_q  <= dv_side.visible;
    end
  end

  assign m_axis_tvalid   = out_valid_q;
  assign m_axis_tdata    = out_data_q;
  assign m_axis_tuser[0] = out_vis_q;

`ifndef SYNTHESIS
  a_invisible_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata == '0)
    else $error("invisible item carries nonzero coordinates");
`endif

endmodule

/* tb/tb_top.sv */
// tb_top: self-checking testbench for vertex_project_to_window_core.
// Drives vertices and matrix registers, predicts each window position in
// 64-bit fixed point and checks every output item in order. Uses vpw_pkg.
`timescale 1ns / 100ps

module tb_top;
  import vpw_pkg::*;

  localparam longint CLIP_W_MIN = ((longint'(1) << 24) + 5000) / 10000;

  typedef struct {
    logic signed [OBJ_W-1:0]  x, y, z;
    logic signed [VIEW_W-1:0] left, bottom;
    logic [VIEW_W-1:0]        width, height;
  } vertex_t;

  typedef struct {
    logic [WIN_W-1:0]   win_x, win_y;
    logic [DEPTH_W-1:0] depth;
    logic               visible;
  } window_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [IN_DATA_W-1:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic [0:0] m_axis_tuser;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  cfg_idx_e cfg_index_i = CFG_MODEL_ROW0;
  logic [ROW_W-1:0] cfg_data_i = '0;

  logic [ROW_W-1:0] model_rows [NUM_ROWS];
  logic [ROW_W-1:0] proj_rows [NUM_ROWS];
  window_t expected_windows[$];
  int errors = 0;
  bit steady_sink = 1'b0;
  bit steady_source = 1'b0;
  int sink_hold = 0;

  vertex_project_to_window_core u_dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  always #5 clk_i = ~clk_i;

  function automatic longint clamp(longint v, int bits);
    longint hi, lo;
    hi = (longint'(1) << (bits - 1)) - 1;
    lo = -hi - 1;
    return v > hi ? hi : (v < lo ? lo : v);
  endfunction

  function automatic longint div_floor(longint n, longint d);
    longint q;
    q = n / d;
    if ((n % d) != 0 && n < 0) q = q - 1;
    return q;
  endfunction

  function automatic longint row_coef(logic [ROW_W-1:0] row, int k);
    logic signed [COEF_W-1:0] c;
    c = row[COEF_W*k +: COEF_W];
    return longint'(c);
  endfunction

  function automatic window_t project_vertex(vertex_t v);
    longint obj[4], eye[4], clip[4];
    longint acc, wdt, hgt, w2;
    window_t r;
    obj[0] = longint'(v.x);
    obj[1] = longint'(v.y);
    obj[2] = longint'(v.z);
    obj[3] = 4096;
    for (int i = 0; i < 4; i++) begin
      acc = 0;
      for (int k = 0; k < 4; k++) acc += row_coef(model_rows[i], k) * obj[k];
      eye[i] = clamp(acc, 32);
    end
    for (int i = 0; i < 4; i++) begin
      acc = 0;
      for (int k = 0; k < 4; k++) acc += row_coef(proj_rows[i], k) * eye[k];
      clip[i] = clamp(acc >>> 12, 32);
    end
    r = '{default: '0};
    if (clip[3] < CLIP_W_MIN) return r;
    wdt = (v.width > VIEW_MAX) ? 16384 : longint'(v.width);
    hgt = (v.height > VIEW_MAX) ? 16384 : longint'(v.height);
    w2 = 2 * clip[3];
    r.win_x = WIN_W'(clamp(longint'(v.left) * 256
                           + div_floor((clip[3] + clip[0]) * wdt * 256, w2), WIN_W));
    r.win_y = WIN_W'(clamp(longint'(v.bottom) * 256
                           + div_floor((clip[3] + clip[1]) * hgt * 256, w2), WIN_W));
    r.depth = DEPTH_W'(clamp(div_floor((clip[3] + clip[2]) * 4096, w2), DEPTH_W));
    r.visible = 1'b1;
    return r;
  endfunction

  function automatic logic [ROW_W-1:0] pack_row(int c0, int c1, int c2, int c3);
    return {16'(c3), 16'(c2), 16'(c1), 16'(c0)};
  endfunction

  // output side: random stalls, steady ready, forced hold-off on request
  always @(posedge clk_i) begin
    if (sink_hold > 0) begin
      m_axis_tready <= 1'b0;
      sink_hold <= sink_hold - 1;
    end else if (steady_sink) begin
      m_axis_tready <= 1'b1;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= 24);
    end
  end

  always @(posedge clk_i) begin
    window_t got, exp_w;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.win_x = m_axis_tdata[23:0];
      got.win_y = m_axis_tdata[47:24];
      got.depth = m_axis_tdata[63:48];
      got.visible = m_axis_tuser[0];
      if (expected_windows.size() == 0) begin
        $display("%0t: unexpected item x=%h y=%h d=%h vis=%b", $time,
                 got.win_x, got.win_y, got.depth, got.visible);
        errors++;
      end else begin
        exp_w = expected_windows.pop_front();
        if (got.win_x !== exp_w.win_x) begin
          $display("%0t: win_x exp %h got %h", $time, exp_w.win_x, got.win_x);
          errors++;
        end
        if (got.win_y !== exp_w.win_y) begin
          $display("%0t: win_y exp %h got %h", $time, exp_w.win_y, got.win_y);
          errors++;
        end
        if (got.depth !== exp_w.depth) begin
          $display("%0t: depth exp %h got %h", $time, exp_w.depth, got.depth);
          errors++;
        end
        if (got.visible !== exp_w.visible) begin
          $display("%0t: visible exp %b got %b", $time, exp_w.visible, got.visible);
          errors++;
        end
      end
    end
  end

  // tvalid stays high after the accepting edge; the next call or drain decides
  task automatic send_vertex(vertex_t v);
    if (!steady_source && $urandom_range(99) < 24) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {4'b0, v.height, v.width, v.bottom, v.left, v.z, v.y, v.x};
    do @(posedge clk_i); while (!s_axis_tready);
    expected_windows.push_back(project_vertex(v));
  endtask

  task automatic write_row(cfg_idx_e idx, logic [ROW_W-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (idx < CFG_PROJ_ROW0) model_rows[2'(idx)] = val;
    else proj_rows[2'(idx - CFG_PROJ_ROW0)] = val;
    @(posedge clk_i);
  endtask

  task automatic drain;
    s_axis_tvalid <= 1'b0;
    while (expected_windows.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  function automatic vertex_t random_vertex();
    vertex_t v;
    v.x = OBJ_W'($urandom);
    v.y = OBJ_W'($urandom);
    v.z = OBJ_W'($urandom);
    if ($urandom_range(3) != 0) begin
      v.x = $signed(v.x) >>> $urandom_range(0, 3);
      v.y = $signed(v.y) >>> $urandom_range(0, 3);
      v.z = $signed(v.z) >>> $urandom_range(0, 3);
    end
    v.left = VIEW_W'($urandom);
    v.bottom = VIEW_W'($urandom);
    v.width = ($urandom_range(9) == 0) ? VIEW_W'($urandom) : VIEW_W'($urandom_range(0, 16384));
    v.height = ($urandom_range(9) == 0) ? VIEW_W'($urandom) : VIEW_W'($urandom_range(0, 16384));
    return v;
  endfunction

  function automatic int jitter(int span);
    return $urandom_range(0, 2 * span) - span;
  endfunction

  // near-affine model and perspective-like projection keep most points visible
  task automatic load_perspective_setup();
    for (int i = 0; i < 3; i++) begin
      write_row(cfg_idx_e'(i), pack_row(i == 0 ? 4096 + jitter(2048) : jitter(1024),
                                        i == 1 ? 4096 + jitter(2048) : jitter(1024),
                                        i == 2 ? 4096 + jitter(2048) : jitter(1024),
                                        jitter(4096)));
      write_row(cfg_idx_e'(i + 4), pack_row(i == 0 ? 4096 + jitter(4000) : jitter(512),
                                            i == 1 ? 4096 + jitter(4000) : jitter(512),
                                            i == 2 ? 4096 + jitter(4000) : jitter(512),
                                            jitter(2048)));
    end
    write_row(CFG_MODEL_ROW3, pack_row(0, 0, 0, 4096));
    write_row(CFG_PROJ_ROW3, pack_row(jitter(256), jitter(256), jitter(1024),
                                      $urandom_range(4096, 16000)));
  endtask

  task automatic load_random_setup();
    for (int i = 0; i < 8; i++) write_row(cfg_idx_e'(i), {$urandom, $urandom});
  endtask

  task automatic run_random(int count);
    for (int n = 0; n < count; n++) send_vertex(random_vertex());
  endtask

  task automatic test_identity_extremes();
    vertex_t v;
    int vals[4] = '{-32768, 32767, 0, 4096};
    for (int i = 0; i < 4; i++) begin
      v.x = OBJ_W'(vals[i]); v.y = OBJ_W'(vals[3 - i]); v.z = OBJ_W'(vals[(i + 1) % 4]);
      v.left = VIEW_W'((i % 2) ? -16384 : 16383);
      v.bottom = VIEW_W'((i % 2) ? 16383 : -16384);
      v.width = VIEW_W'((i < 2) ? 16384 : 0);
      v.height = VIEW_W'((i < 2) ? 0 : 16384);
      send_vertex(v);
    end
    v.width = 15'h7FFF; v.height = 15'h7FFF;
    send_vertex(v);
    v.width = 15'd16385; v.height = 15'd1;
    send_vertex(v);
    drain();
  endtask

  task automatic test_invisible_and_huge_ratio();
    vertex_t v;
    v = '{x: 16'sd4096, y: -16'sd4096, z: 16'sd2048, left: 15'sd100,
          bottom: -15'sd100, width: 15'd640, height: 15'd480};
    write_row(CFG_PROJ_ROW3, '0);
    send_vertex(v);
    drain();
    write_row(CFG_PROJ_ROW3, pack_row(0, 0, 0, -4096));
    send_vertex(v);
    drain();
    // w above the clip threshold, then a w of zero below it
    write_row(CFG_PROJ_ROW3, pack_row(0, 0, 0, 1));
    send_vertex(v);
    drain();
    write_row(CFG_PROJ_ROW3, pack_row(0, 0, 0, 0));
    write_row(CFG_MODEL_ROW3, pack_row(0, 0, 0, 1678 >> 12));
    send_vertex(v);
    drain();
    write_row(CFG_PROJ_ROW3, pack_row(0, 0, 0, 4096));
    write_row(CFG_MODEL_ROW3, pack_row(0, 0, 0, 1));
    send_vertex(v);
    v.x = 16'sh7FFF; v.y = 16'sh8000; v.z = 16'sh8000;
    send_vertex(v);
    drain();
    write_row(CFG_MODEL_ROW3, pack_row(0, 0, 0, 4096));
  endtask

  task automatic test_saturated_matrices();
    vertex_t v;
    for (int i = 0; i < 8; i++) write_row(cfg_idx_e'(i), {4{16'h7FFF}});
    v = '{x: 16'sh7FFF, y: 16'sh7FFF, z: 16'sh7FFF, left: 15'sd0, bottom: 15'sd0,
          width: 15'd16384, height: 15'd16384};
    send_vertex(v);
    v.x = 16'sh8000; v.y = 16'sh8000; v.z = 16'sh8000;
    send_vertex(v);
    drain();
    for (int i = 0; i < 8; i++) write_row(cfg_idx_e'(i), {4{16'h8000}});
    send_vertex(v);
    v.x = 16'sh7FFF; v.y = '0; v.z = 16'sh7FFF;
    send_vertex(v);
    drain();
  endtask

  task automatic test_random_setups();
    for (int phase = 0; phase < 10; phase++) begin
      if (phase % 4 == 3) load_random_setup();
      else load_perspective_setup();
      steady_source = (phase == 5);
      steady_sink = (phase == 5);
      run_random(65);
      drain();
    end
    steady_source = 1'b0;
    steady_sink = 1'b0;
  endtask

  task automatic test_backpressure();
    load_perspective_setup();
    steady_source = 1'b1;
    sink_hold = 300;
    run_random(100);
    steady_source = 1'b0;
    drain();
  endtask

  initial begin
    for (int i = 0; i < NUM_ROWS; i++) begin
      model_rows[i] = IDENT_ONE << (16 * i);
      proj_rows[i] = IDENT_ONE << (16 * i);
    end
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_identity_extremes();
    test_invisible_and_huge_ratio();
    test_saturated_matrices();
    test_random_setups();
    test_backpressure();
    drain();
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule

/* sim.f */
hw/rtl/vpw_pkg.sv
hw/rtl/vpw_matvec.sv
hw/rtl/vpw_setup.sv
hw/rtl/vpw_divider.sv
hw/rtl/vertex_project_to_window_core.sv
tb/tb_top.sv
